// ----- hdl/qpr_pkg.sv -----
// Shared types, widths and the round/saturate helper for the quaternion
// point rotation block. No dependencies; used by qpr_core and the top level.
package qpr_pkg;

  // Q2.14 coefficient width
  localparam int unsigned CoefW = 16;
  // Q2.14 x Q2.14 product, Q4.28
  localparam int unsigned P1W   = 2 * CoefW;
  // sum of three stage-one products, Q4.28 with headroom
  localparam int unsigned TW    = P1W + 2;
  // Q2.14 x stage-one term, Q8.42
  localparam int unsigned P2W   = CoefW + TW;
  // sum of four stage-two products plus rounding headroom
  localparam int unsigned AccW  = P2W + 3;
  // Q11.42 -> Q2.14 drops this many fraction bits
  localparam int unsigned FracShift = 28;
  // width of the rounded value before saturation
  localparam int unsigned RndW  = AccW - FracShift;

  localparam logic signed [AccW-1:0] HalfLsb = AccW'(1) << (FracShift - 1);
  localparam logic signed [RndW-1:0] OutMax  = RndW'(32767);
  localparam logic signed [RndW-1:0] OutMin  = -RndW'(32768);

  // APB register map, word index paddr[3:2]
  typedef enum logic [1:0] {
    REG_ROT_W = 2'd0,
    REG_ROT_X = 2'd1,
    REG_ROT_Y = 2'd2,
    REG_ROT_Z = 2'd3
  } reg_addr_e;

  typedef logic signed [CoefW-1:0] coef_t;

  // rotation quaternion
  typedef struct packed {
    coef_t w;
    coef_t x;
    coef_t y;
    coef_t z;
  } quat_t;

  // 3D point, x in the lowest bits
  typedef struct packed {
    coef_t z;
    coef_t y;
    coef_t x;
  } point_t;

  typedef struct packed {
    coef_t val;
    logic  clip;
  } rnd_t;

  // Round to nearest (ties toward +inf) by floor((acc + 2^27) / 2^28),
  // then clip to the 16-bit range.
  function automatic rnd_t round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] biased;
    logic signed [RndW-1:0] r;
    rnd_t                   res;
    biased = acc + HalfLsb;
    r      = biased[AccW-1:FracShift];
    if (r > OutMax) begin
      res.val  = coef_t'(OutMax);
      res.clip = 1'b1;
    end else if (r < OutMin) begin
      res.val  = coef_t'(OutMin);
      res.clip = 1'b1;
    end else begin
      res.val  = r[CoefW-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- hdl/qpr_core.sv -----
// Five-stage rotation datapath: products, terms, products, sums, round.
// Depends on qpr_pkg. Each stage holds its own valid bit and advances alone.
module qpr_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qpr_pkg::quat_t  quat_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qpr_pkg::point_t in_point_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output qpr_pkg::point_t out_point_o,
  output logic            out_sat_o
);
  import qpr_pkg::*;

  // per-stage valid bits and advance enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1: point x quaternion products, index [point comp][w,x,y,z]
  logic signed [P1W-1:0] p1_q [3][4];
  // stage 2: terms tw, tx, ty, tz
  logic signed [TW-1:0]  tw_q, tx_q, ty_q, tz_q;
  // stage 3: quaternion x term products
  logic signed [P2W-1:0] awx_q, axw_q, ayz_q, azy_q;
  logic signed [P2W-1:0] bwy_q, bxz_q, byw_q, bzx_q;
  logic signed [P2W-1:0] cwz_q, cxy_q, cyx_q, czw_q;
  // stage 4: coordinate sums, Q11.42
  logic signed [AccW-1:0] ax_q, ay_q, az_q;
  // stage 5: output register
  point_t out_q;
  logic   sat_q;

  rnd_t rx, ry, rz;
  coef_t qv [4];
  coef_t pv [3];

  assign qv[0] = quat_i.w;
  assign qv[1] = quat_i.x;
  assign qv[2] = quat_i.y;
  assign qv[3] = quat_i.z;
  assign pv[0] = in_point_i.x;
  assign pv[1] = in_point_i.y;
  assign pv[2] = in_point_i.z;

  // a stage loads when empty or when its content moves on
  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: twelve 16x16 products
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1_q[i][j] <= pv[i] * qv[j];
        end
      end
    end
  end

  // stage 2: t = (0,p) * conj(q)
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      tw_q <=  TW'(p1_q[0][1]) + TW'(p1_q[1][2]) + TW'(p1_q[2][3]);
      tx_q <=  TW'(p1_q[0][0]) - TW'(p1_q[1][3]) + TW'(p1_q[2][2]);
      ty_q <=  TW'(p1_q[0][3]) + TW'(p1_q[1][0]) - TW'(p1_q[2][1]);
      tz_q <= -TW'(p1_q[0][2]) + TW'(p1_q[1][1]) + TW'(p1_q[2][0]);
    end
  end

  // stage 3: q x t products
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      awx_q <= quat_i.w * tx_q;
      axw_q <= quat_i.x * tw_q;
      ayz_q <= quat_i.y * tz_q;
      azy_q <= quat_i.z * ty_q;
      bwy_q <= quat_i.w * ty_q;
      bxz_q <= quat_i.x * tz_q;
      byw_q <= quat_i.y * tw_q;
      bzx_q <= quat_i.z * tx_q;
      cwz_q <= quat_i.w * tz_q;
      cxy_q <= quat_i.x * ty_q;
      cyx_q <= quat_i.y * tx_q;
      czw_q <= quat_i.z * tw_q;
    end
  end

  // stage 4: vector part of q * t
  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      ax_q <= AccW'(awx_q) + AccW'(axw_q) + AccW'(ayz_q) - AccW'(azy_q);
      ay_q <= AccW'(bwy_q) - AccW'(bxz_q) + AccW'(byw_q) + AccW'(bzx_q);
      az_q <= AccW'(cwz_q) + AccW'(cxy_q) - AccW'(cyx_q) + AccW'(czw_q);
    end
  end

  // stage 5: round, saturate and hold for the receiver
  always_comb begin
    rx = round_sat(ax_q);
    ry = round_sat(ay_q);
    rz = round_sat(az_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      out_q.x <= rx.val;
      out_q.y <= ry.val;
      out_q.z <= rz.val;
      sat_q   <= rx.clip | ry.clip | rz.clip;
    end
  end

  assign out_valid_o = v5_q;
  assign out_point_o = out_q;
  assign out_sat_o   = sat_q;

`ifndef SYNTHESIS
  // input only backs up when every stage is full
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted transaction lands in stage 1
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted transaction lost at stage 1");

  // a stalled stage 4 item stays valid with its x and z sums unchanged
  a_stage4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !rdy5) |=> (v4_q && $stable(ax_q) && $stable(az_q)))
    else $error("stage 4 changed while stalled");

  // output empties when taken and nothing follows
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out_ready_i && !v4_q) |=> !v5_q)
    else $error("output transaction repeated");
`endif

endmodule

// ----- hdl/quaternion_point_rotation.sv -----
// Quaternion point rotation top level: APB quaternion registers and stream ports.
// Depends on qpr_pkg and qpr_core.
//
// Usage:
//   Program rot_w/x/y/z (signed Q2.14) over APB at byte addresses 0, 4, 8, 12
//   while no transaction is in flight. Points enter on the s_* stream,
//   tdata = {point_z, point_y, point_x}; rotated points leave on the m_*
//   stream, tdata = {rotated_z, rotated_y, rotated_x}, tuser = saturated.
// Pipeline: five register stages (products, terms, products, sums,
//   round/saturate register); an accepted point passes through them in order
//   and m_tvalid rises once it is held in the round/saturate register.
// Throughput: one point per cycle while m_tready is high; each stage has its
//   own valid bit and the five-stage multiply/add pipeline sets the latency.
// Reset: the quaternion returns to identity (1.0, 0, 0, 0) and the pipeline
//   empties; no clearing pass is needed.
// Stall: when m_tready is low the output holds; upstream stages keep
//   filling bubbles and s_tready drops only when all five stages are full.
//   No transaction is lost or repeated.
module quaternion_point_rotation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // point_x [15:0], point_y [31:16], point_z [47:32]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // rotated_x [15:0], rotated_y [31:16], rotated_z [47:32]
  output logic        m_tuser    // saturated [0]
);
  import qpr_pkg::*;

  quat_t     quat_q;
  reg_addr_e reg_sel;
  logic      wr_en;
  point_t    in_point;
  point_t    out_point;
  coef_t     rd_val;

  assign pready  = 1'b1;
  assign reg_sel = reg_addr_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // quaternion registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.w <= coef_t'(16384);
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ROT_W: quat_q.w <= pwdata[CoefW-1:0];
        REG_ROT_X: quat_q.x <= pwdata[CoefW-1:0];
        REG_ROT_Y: quat_q.y <= pwdata[CoefW-1:0];
        REG_ROT_Z: quat_q.z <= pwdata[CoefW-1:0];
      endcase
    end
  end

  // register readback, sign extended
  always_comb begin
    unique case (reg_sel)
      REG_ROT_W: rd_val = quat_q.w;
      REG_ROT_X: rd_val = quat_q.x;
      REG_ROT_Y: rd_val = quat_q.y;
      REG_ROT_Z: rd_val = quat_q.z;
    endcase
  end
  assign prdata = 32'(rd_val);

  assign in_point = point_t'(s_tdata);
  assign m_tdata  = 48'(out_point);

  qpr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quat_i      (quat_q),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_point_i  (in_point),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_point_o (out_point),
    .out_sat_o   (m_tuser)
  );

endmodule
